/* src/abfp_pkg.sv */
`default_nettype none

package abfp_pkg;

    // Field ids, numbered in stream order with gaps
    localparam logic [5:0] F_BSID       = 6'd0;
    localparam logic [5:0] F_ACMOD      = 6'd2;
    localparam logic [5:0] F_CHANS      = 6'd3;
    localparam logic [5:0] F_CMIXLEV    = 6'd4;
    localparam logic [5:0] F_SURMIXLEV  = 6'd5;
    localparam logic [5:0] F_DSURMOD    = 6'd6;
    localparam logic [5:0] F_LFEON      = 6'd7;
    localparam logic [5:0] F_COMPRE     = 6'd9;
    localparam logic [5:0] F_COMPR      = 6'd10;
    localparam logic [5:0] F_LANGCODE   = 6'd11;
    localparam logic [5:0] F_LANGCOD    = 6'd12;
    localparam logic [5:0] F_AUDPRODIE  = 6'd13;
    localparam logic [5:0] F_MIXLEVEL   = 6'd14;
    localparam logic [5:0] F_ROOMTYP    = 6'd15;
    localparam logic [5:0] F_DIALNORM2  = 6'd16;
    localparam logic [5:0] F_COMPR2E    = 6'd17;
    localparam logic [5:0] F_COMPR2     = 6'd18;
    localparam logic [5:0] F_LANGCOD2E  = 6'd19;
    localparam logic [5:0] F_LANGCOD2   = 6'd20;
    localparam logic [5:0] F_AUDPRODI2E = 6'd21;
    localparam logic [5:0] F_MIXLEVEL2  = 6'd22;
    localparam logic [5:0] F_COPYRIGHTB = 6'd24;
    localparam logic [5:0] F_TIMECOD1E  = 6'd26;
    localparam logic [5:0] F_TIMECOD1   = 6'd27;
    localparam logic [5:0] F_TIMECOD2E  = 6'd28;
    localparam logic [5:0] F_TIMECOD2   = 6'd29;
    localparam logic [5:0] F_ADDBSIE    = 6'd30;
    localparam logic [5:0] F_ADDBSIL    = 6'd31;
    localparam logic [5:0] F_ADDBSI     = 6'd32;
    localparam logic [5:0] F_COUNT      = 6'd33;
    localparam logic [5:0] POS_IDLE     = 6'd63;

    // Coding modes that gate optional fields
    localparam logic [2:0] ACMOD_DUAL = 3'd0;
    localparam logic [2:0] ACMOD_1_0  = 3'd1;
    localparam logic [2:0] ACMOD_2_0  = 3'd2;

    // Bit width of each field, in field id order
    localparam logic [3:0] FIELD_WIDTH [33] = '{
        4'd5, 4'd3, 4'd3, 4'd0, 4'd2, 4'd2, 4'd2, 4'd1, 4'd5, 4'd1, 4'd8,
        4'd1, 4'd8, 4'd1, 4'd5, 4'd2, 4'd5, 4'd1, 4'd8, 4'd1, 4'd8, 4'd1,
        4'd5, 4'd2, 4'd1, 4'd1, 4'd1, 4'd14, 4'd1, 4'd14, 4'd1, 4'd6, 4'd8
    };

    // Full-bandwidth channel count per coding mode
    localparam logic [2:0] CHAN_COUNT [8] = '{
        3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [5:0]  id;
        logic [13:0] val;
        logic [5:0]  idx;
        logic        done;
    } fld_res_t;

    typedef struct packed {
        fld_res_t res;
        logic     last;
    } fld_beat_t;

    function automatic logic [3:0] fld_width(input logic [5:0] id);
        logic [3:0] w;
        begin
            w = 4'd0;
            if (id < F_COUNT)
                w = FIELD_WIDTH[id];
            return w;
        end
    endfunction

    // First field at or after id that the coding mode calls for
    function automatic logic [5:0] mode_pick(input logic [5:0] id, input logic [2:0] cm);
        logic [5:0] r;
        begin
            r = id;
            // center mix level only with a center among three front channels
            if (r == F_CMIXLEV && !(cm[0] && cm != ACMOD_1_0))
                r = F_SURMIXLEV;
            // surround mix level only with surround channels
            if (r == F_SURMIXLEV && !cm[2])
                r = F_DSURMOD;
            if (r == F_DSURMOD && cm != ACMOD_2_0)
                r = F_LFEON;
            // second set only in dual mono
            if (r == F_DIALNORM2 && cm != ACMOD_DUAL)
                r = F_COPYRIGHTB;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* src/ac3_bsi_field_parser_core.sv */
// Throughput: one bit per cycle unless a result push stalls, pausing after acmod for the
//   channel count; a byte where the header ends mid-byte stops after its last header bit,
//   and bytes outside a header are not shifted. At most one result per cycle.
// Results: a field is held until the next result of its byte forms, then pushed; the last
//   result of a byte is pushed once the byte's final bit has been shifted.
// Reset: asynchronous, active low; queues empty, parser idle until a frame start.
`default_nettype none

module ac3_bsi_field_parser_core
    import abfp_pkg::*;
#(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_start,
    input  wire logic        pop,
    output logic             empty,
    output logic [5:0]       field_id,
    output logic [13:0]      field_value,
    output logic [5:0]       element_index,
    output logic             header_done,
    output logic             run_last
);

    logic       in_empty, in_pop;
    logic [8:0] in_rdata;
    logic       out_push, out_full;
    fld_beat_t  out_beat, out_head;

    // Front: queue incoming bytes
    abfp_fifo #(
        .WIDTH (9),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({frame_start, data_byte}),
        .full  (full),
        .pop   (in_pop),
        .rdata (in_rdata),
        .empty (in_empty)
    );

    // Back: shift bits through the header field sequence
    abfp_bit_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (!in_empty),
        .in_byte  (in_rdata[7:0]),
        .in_start (in_rdata[8]),
        .in_pop   (in_pop),
        .out_push (out_push),
        .out_beat (out_beat),
        .out_full (out_full)
    );

    // Result queue toward the consumer
    abfp_fifo #(
        .WIDTH ($bits(fld_beat_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_beat),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_head),
        .empty (empty)
    );

    assign field_id      = out_head.res.id;
    assign field_value   = out_head.res.val;
    assign element_index = out_head.res.idx;
    assign header_done   = out_head.res.done;
    assign run_last      = out_head.last;

endmodule

`default_nettype wire

/* src/abfp_fifo.sv */
`default_nettype none

module abfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store beat payload
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* src/abfp_bit_engine.sv */
`default_nettype none

module abfp_bit_engine
    import abfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_vld,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_start,
    output logic            in_pop,
    output logic            out_push,
    output fld_beat_t       out_beat,
    input  wire logic       out_full
);

    // Parse state
    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  rem_reg, rem_next;
    logic [13:0] shift_reg, shift_next;
    logic [2:0]  cm_reg, cm_next;
    logic [6:0]  ebl_reg, ebl_next;
    logic [5:0]  ebi_reg, ebi_next;
    // Byte being shifted out
    logic        act_reg, act_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  cnt_reg, cnt_next;
    // Result held until the next one shows whether it ends the byte
    logic        hold_vld_reg, hold_vld_next;
    fld_res_t    hold_reg, hold_next;
    logic        x_vld_reg, x_vld_next;
    logic [2:0]  x_chan_reg, x_chan_next;
    logic        end_reg, end_next;

    // Bit step decode
    logic        bit_cyc, brk, new_res, fin, flag, two, stall, push_want, ld;
    logic [13:0] nshift;
    logic [3:0]  nrem;
    logic [5:0]  nx;
    logic [2:0]  cm_c, chan_c;
    logic [6:0]  ebl_c;
    logic [5:0]  ebi_c;
    fld_res_t    res_c, chan_res;

    assign bit_cyc = act_reg && !x_vld_reg;
    assign brk     = (pos_reg >= F_COUNT) || (rem_reg == 4'd0);
    assign nshift  = {shift_reg[12:0], byte_reg[7]};
    assign nrem    = rem_reg - 4'd1;
    assign flag    = (nshift != 14'd0);
    assign new_res = bit_cyc && !brk && (nrem == 4'd0);
    assign fin     = bit_cyc && (brk || cnt_reg == 3'd7);

    always_comb
    begin
        chan_res.id   = F_CHANS;
        chan_res.val  = {11'd0, x_chan_reg};
        chan_res.idx  = 6'd0;
        chan_res.done = 1'b0;
    end

    // Decode the completed field: result, next field, side effects
    always_comb
    begin
        res_c.id   = pos_reg;
        res_c.val  = nshift;
        res_c.idx  = 6'd0;
        res_c.done = 1'b0;
        nx     = pos_reg + 6'd1;
        cm_c   = cm_reg;
        ebl_c  = ebl_reg;
        ebi_c  = ebi_reg;
        two    = 1'b0;
        chan_c = CHAN_COUNT[nshift[2:0]];
        case (pos_reg)
            F_ACMOD:
            begin
                cm_c = nshift[2:0];
                two  = 1'b1;
                nx   = mode_pick(F_CMIXLEV, nshift[2:0]);
            end
            F_CMIXLEV:    nx = mode_pick(F_SURMIXLEV, cm_reg);
            F_SURMIXLEV:  nx = mode_pick(F_DSURMOD, cm_reg);
            F_COMPRE:     nx = flag ? F_COMPR : F_LANGCODE;
            F_LANGCODE:   nx = flag ? F_LANGCOD : F_AUDPRODIE;
            F_AUDPRODIE:  nx = flag ? F_MIXLEVEL : mode_pick(F_DIALNORM2, cm_reg);
            F_ROOMTYP:    nx = mode_pick(F_DIALNORM2, cm_reg);
            F_COMPR2E:    nx = flag ? F_COMPR2 : F_LANGCOD2E;
            F_LANGCOD2E:  nx = flag ? F_LANGCOD2 : F_AUDPRODI2E;
            F_AUDPRODI2E: nx = flag ? F_MIXLEVEL2 : F_COPYRIGHTB;
            F_TIMECOD1E:  nx = flag ? F_TIMECOD1 : F_TIMECOD2E;
            F_TIMECOD2E:  nx = flag ? F_TIMECOD2 : F_ADDBSIE;
            F_ADDBSIE:
            begin
                res_c.done = !flag;
                nx         = flag ? F_ADDBSIL : POS_IDLE;
            end
            F_ADDBSIL:
            begin
                ebl_c = {1'b0, nshift[5:0]} + 7'd1;
                ebi_c = 6'd0;
                nx    = F_ADDBSI;
            end
            F_ADDBSI:
            begin
                res_c.idx = ebi_reg;
                if (ebl_reg <= 7'd1)
                begin
                    res_c.done = 1'b1;
                    ebl_c      = 7'd0;
                    nx         = POS_IDLE;
                end
                else
                begin
                    ebl_c = ebl_reg - 7'd1;
                    ebi_c = ebi_reg + 6'd1;
                    nx    = F_ADDBSI;
                end
            end
            default: ;
        endcase
    end

    // Pick the beat to push this cycle
    always_comb
    begin
        push_want = 1'b0;
        out_beat  = {hold_reg, 1'b0};
        if (x_vld_reg)
            push_want = 1'b1;
        else if (end_reg)
        begin
            push_want = hold_vld_reg;
            out_beat  = {hold_reg, 1'b1};
        end
        else if (new_res)
            push_want = hold_vld_reg;
    end

    assign stall    = push_want && out_full;
    assign out_push = push_want && !out_full;
    assign ld       = !stall && (!act_reg || fin) && in_vld;
    assign in_pop   = ld;

    // Next state; hold everything on a stalled push
    always_comb
    begin
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        shift_next    = shift_reg;
        cm_next       = cm_reg;
        ebl_next      = ebl_reg;
        ebi_next      = ebi_reg;
        act_next      = act_reg;
        byte_next     = byte_reg;
        cnt_next      = cnt_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        x_vld_next    = x_vld_reg;
        x_chan_next   = x_chan_reg;
        end_next      = end_reg;
        if (!stall)
        begin
            // result holding
            if (x_vld_reg)
            begin
                hold_next  = chan_res;
                x_vld_next = 1'b0;
            end
            else
            begin
                if (end_reg)
                begin
                    hold_vld_next = 1'b0;
                    end_next      = 1'b0;
                end
                if (new_res)
                begin
                    hold_next     = res_c;
                    hold_vld_next = 1'b1;
                    x_vld_next    = two;
                    x_chan_next   = chan_c;
                end
                if (fin)
                    end_next = 1'b1;
            end
            // advance one bit
            if (bit_cyc)
            begin
                if (brk)
                    pos_next = POS_IDLE;
                else
                begin
                    shift_next = nshift;
                    rem_next   = nrem;
                    byte_next  = {byte_reg[6:0], 1'b0};
                    cnt_next   = cnt_reg + 3'd1;
                    if (nrem == 4'd0)
                    begin
                        pos_next   = nx;
                        shift_next = 14'd0;
                        rem_next   = fld_width(nx);
                        cm_next    = cm_c;
                        ebl_next   = ebl_c;
                        ebi_next   = ebi_c;
                    end
                end
                if (fin)
                    act_next = 1'b0;
            end
            // take the next byte; a start restarts the header
            if (ld)
            begin
                byte_next = in_byte;
                cnt_next  = 3'd0;
                act_next  = 1'b1;
                if (in_start)
                begin
                    pos_next   = F_BSID;
                    rem_next   = fld_width(F_BSID);
                    shift_next = 14'd0;
                    cm_next    = 3'd0;
                    ebl_next   = 7'd0;
                    ebi_next   = 6'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_IDLE;
            rem_reg      <= 4'd0;
            shift_reg    <= 14'd0;
            cm_reg       <= 3'd0;
            ebl_reg      <= 7'd0;
            ebi_reg      <= 6'd0;
            act_reg      <= 1'b0;
            cnt_reg      <= 3'd0;
            hold_vld_reg <= 1'b0;
            x_vld_reg    <= 1'b0;
            end_reg      <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            rem_reg      <= rem_next;
            shift_reg    <= shift_next;
            cm_reg       <= cm_next;
            ebl_reg      <= ebl_next;
            ebi_reg      <= ebi_next;
            act_reg      <= act_next;
            cnt_reg      <= cnt_next;
            hold_vld_reg <= hold_vld_next;
            x_vld_reg    <= x_vld_next;
            end_reg      <= end_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        hold_reg   <= hold_next;
        x_chan_reg <= x_chan_next;
    end

endmodule

`default_nettype wire
